// File: hw/rtl/scbrp_pkg.sv
// scbrp_pkg: shared types, constants and class table for the block retention pool
// depends on nothing
`timescale 1ns / 1ps
package scbrp_pkg;

  localparam int ClassDepth = 128;
  localparam int ClassCount = 8;
  localparam int ClsW = $clog2(ClassCount);
  localparam int PosW = $clog2(ClassDepth);
  localparam int FillW = $clog2(ClassDepth + 1);
  localparam int AddrW = ClsW + PosW;

  localparam logic [1:0] KindTaken = 2'd0;
  localparam logic [1:0] KindMiss = 2'd1;
  localparam logic [1:0] KindReleased = 2'd2;
  localparam logic [1:0] KindEvicted = 2'd3;

  localparam logic [2:0] RegCountLimit = 3'd0;
  localparam logic [2:0] RegByteLimit = 3'd1;

  typedef struct packed {
    logic        func;
    logic [15:0] size;
    logic [31:0] block_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] block_id_res;
    logic [15:0] block_size;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StTakeRd,
    StPutWr,
    StEvScan,
    StEvRd,
    StEmit
  } state_e;

  // one memory write or read request from control to the slot store
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [31:0]      handle;
    logic [31:0]      age;
  } mem_req_t;

  function automatic logic [15:0] class_bytes(input logic [ClsW-1:0] c);
    logic [15:0] b;
    case (c)
      3'd0: b = 16'd512;
      3'd1: b = 16'd768;
      3'd2: b = 16'd1024;
      3'd3: b = 16'd1536;
      3'd4: b = 16'd2048;
      3'd5: b = 16'd4096;
      3'd6: b = 16'd8192;
      default: b = 16'd32768;
    endcase
    return b;
  endfunction

endpackage

// File: hw/rtl/size_class_block_retention_pool_top.sv
// size_class_block_retention_pool_top: control, queue bookkeeping and config port
// depends on scbrp_pkg and scbrp_slot_mem
//
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_stall   | in_item_t (func, size, block_id)
// out     | out | out_valid/out_stall | out_item_t (kind, handle, size, last)
// cfg     | in  | apb psel/penable    | block cap @0, byte cap @4
//
// take: accept with slot read, then result register; miss and release: accept, result.
// put retained: slot write at accept, then an eviction decision; each eviction adds
// a head scan of all eight classes, a slot read and a result, plus any output stall.
// reset clears all bookkeeping; slots need no clearing.
// a stalled result holds in the output register; the next item waits for it.
`timescale 1ns / 1ps
module size_class_block_retention_pool_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  scbrp_pkg::in_item_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output scbrp_pkg::out_item_t  out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int ClsW = scbrp_pkg::ClsW;
  localparam int PosW = scbrp_pkg::PosW;
  localparam int FillW = scbrp_pkg::FillW;
  localparam int Cnt = scbrp_pkg::ClassCount;

  scbrp_pkg::state_e state_q, state_d;
  logic [PosW-1:0]  head_q [Cnt];
  logic [PosW-1:0]  head_d [Cnt];
  logic [FillW-1:0] fill_q [Cnt];
  logic [FillW-1:0] fill_d [Cnt];
  logic [10:0] tcount_q, tcount_d;
  logic [25:0] tbytes_q, tbytes_d;
  logic [31:0] age_q, age_d;
  logic [10:0] climit_q;
  logic [25:0] blimit_q;
  logic [ClsW-1:0] sel_q, sel_d;
  logic [ClsW-1:0] scan_q, scan_d;
  logic [31:0] best_age_q, best_age_d;
  logic        found_q, found_d;
  logic        ovalid_q, ovalid_d;
  scbrp_pkg::out_item_t odata_q, odata_d;
  scbrp_pkg::mem_req_t  mreq;
  logic        mre;
  logic [31:0] rd_handle, rd_age;

  scbrp_slot_mem u_mem (
    .clk_i   (clk_i),
    .re_i    (mre),
    .req_i   (mreq),
    .handle_o(rd_handle),
    .age_o   (rd_age)
  );

  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      1'b0: prdata = {21'd0, climit_q};
      default: prdata = {6'd0, blimit_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      climit_q <= 11'd1024;
      blimit_q <= 26'h3FFFFFF;
    end else if (psel && penable && pwrite && tcount_q == 11'd0) begin
      if (paddr == {scbrp_pkg::RegCountLimit[0], 2'b00}) climit_q <= pwdata[10:0];
      else if (paddr == {scbrp_pkg::RegByteLimit[0], 2'b00}) blimit_q <= pwdata[25:0];
    end
  end

  // class search helpers for take and put
  logic [ClsW-1:0] first_c, big_c, put_c;
  logic first_ok, big_ok, put_ok, waste;
  logic [15:0] req, fb;
  logic [22:0] q25;
  always_comb begin
    req = in_data_i.size;
    first_ok = 1'b0; first_c = '0;
    big_ok = 1'b0; big_c = '0;
    put_ok = 1'b0; put_c = '0;
    for (int c = Cnt - 1; c >= 0; c--) begin
      if (fill_q[c] != '0 && scbrp_pkg::class_bytes(ClsW'(c)) >= req) begin
        first_ok = 1'b1; first_c = ClsW'(c);
      end
      if (scbrp_pkg::class_bytes(ClsW'(c)) == req) begin
        put_ok = 1'b1; put_c = ClsW'(c);
      end
    end
    for (int c = 0; c < Cnt; c++) begin
      if (fill_q[c] != '0) begin
        big_ok = 1'b1; big_c = ClsW'(c);
      end
    end
    fb = scbrp_pkg::class_bytes(first_c);
    // a quarter of the request, rounded down
    q25 = 23'(req[15:2]);
    waste = (fb != req) && (23'(fb - req) > q25);
  end

  logic in_acc;
  assign in_stall_o = (state_q != scbrp_pkg::StIdle) || ovalid_q;
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_valid_o = ovalid_q;
  assign out_data_o = odata_q;

  logic over;
  logic [ClsW-1:0] tsel;
  logic [PosW:0] psum;
  always_comb begin
    state_d = state_q;
    head_d = head_q; fill_d = fill_q;
    tcount_d = tcount_q; tbytes_d = tbytes_q; age_d = age_q;
    sel_d = sel_q; scan_d = scan_q; best_age_d = best_age_q; found_d = found_q;
    ovalid_d = ovalid_q && out_stall_i;
    odata_d = odata_q;
    mreq = '0; mre = 1'b0;
    tsel = waste && big_ok ? big_c : first_c;
    psum = '0;
    over = (tcount_q > climit_q) || (tbytes_q > blimit_q);
    unique case (state_q)
      scbrp_pkg::StIdle: begin
        if (in_acc) begin
          if (!in_data_i.func) begin
            if (!first_ok) begin
              ovalid_d = 1'b1;
              odata_d = '{scbrp_pkg::KindMiss, 32'd0, 16'd0, 1'b1};
            end else begin
              psum = {1'b0, head_q[tsel]} + PosW'(fill_q[tsel] - 1'b1);
              if (psum >= (PosW+1)'(scbrp_pkg::ClassDepth))
                psum = psum - (PosW+1)'(scbrp_pkg::ClassDepth);
              mre = 1'b1;
              mreq.addr = {tsel, psum[PosW-1:0]};
              fill_d[tsel] = fill_q[tsel] - 1'b1;
              tcount_d = tcount_q - 1'b1;
              tbytes_d = tbytes_q - 26'(scbrp_pkg::class_bytes(tsel));
              sel_d = tsel;
              state_d = scbrp_pkg::StTakeRd;
            end
          end else if (!put_ok || climit_q == '0 || blimit_q < 26'(in_data_i.size)
                       || fill_q[put_c] >= FillW'(scbrp_pkg::ClassDepth)) begin
            ovalid_d = 1'b1;
            odata_d = '{scbrp_pkg::KindReleased, in_data_i.block_id, in_data_i.size, 1'b1};
          end else begin
            psum = {1'b0, head_q[put_c]} + PosW'(fill_q[put_c]);
            if (psum >= (PosW+1)'(scbrp_pkg::ClassDepth))
              psum = psum - (PosW+1)'(scbrp_pkg::ClassDepth);
            mreq = '{1'b1, {put_c, psum[PosW-1:0]}, in_data_i.block_id, age_q};
            age_d = age_q + 1'b1;
            fill_d[put_c] = fill_q[put_c] + 1'b1;
            tcount_d = tcount_q + 1'b1;
            tbytes_d = tbytes_q + 26'(in_data_i.size);
            state_d = scbrp_pkg::StPutWr;
          end
        end
      end
      scbrp_pkg::StTakeRd: begin
        ovalid_d = 1'b1;
        odata_d = '{scbrp_pkg::KindTaken, rd_handle, scbrp_pkg::class_bytes(sel_q), 1'b1};
        state_d = scbrp_pkg::StIdle;
      end
      scbrp_pkg::StPutWr: begin
        // decide whether evictions follow; scan class heads one per cycle
        if (!ovalid_q || !out_stall_i) begin
          if (over && tcount_q != '0) begin
            scan_d = '0; found_d = 1'b0;
            mre = fill_q[0] != '0;
            mreq.addr = {ClsW'(0), head_q[0]};
            state_d = scbrp_pkg::StEvScan;
          end else begin
            if (ovalid_q) odata_d.last = 1'b1;
            state_d = scbrp_pkg::StIdle;
          end
        end
      end
      scbrp_pkg::StEvScan: begin
        // rd_age holds the head age of the class read in the previous cycle
        if (fill_q[scan_q] != '0 && (!found_q || rd_age < best_age_q)) begin
          found_d = 1'b1; best_age_d = rd_age; sel_d = scan_q;
        end
        if (scan_q == ClsW'(Cnt - 1)) begin
          state_d = scbrp_pkg::StEvRd;
        end else begin
          scan_d = scan_q + 1'b1;
          mre = fill_q[scan_d] != '0;
          mreq.addr = {scan_d, head_q[scan_d]};
        end
      end
      scbrp_pkg::StEvRd: begin
        mre = 1'b1;
        mreq.addr = {sel_q, head_q[sel_q]};
        head_d[sel_q] = (head_q[sel_q] == PosW'(scbrp_pkg::ClassDepth - 1))
                        ? '0 : head_q[sel_q] + 1'b1;
        fill_d[sel_q] = fill_q[sel_q] - 1'b1;
        tcount_d = tcount_q - 1'b1;
        tbytes_d = tbytes_q - 26'(scbrp_pkg::class_bytes(sel_q));
        state_d = scbrp_pkg::StEmit;
      end
      scbrp_pkg::StEmit: begin
        if (!ovalid_q || !out_stall_i) begin
          ovalid_d = 1'b1;
          odata_d = '{scbrp_pkg::KindEvicted, rd_handle, scbrp_pkg::class_bytes(sel_q),
                      !over || tcount_q == '0};
          if (!over || tcount_q == '0) begin
            state_d = scbrp_pkg::StIdle;
          end else begin
            scan_d = '0; found_d = 1'b0;
            mre = fill_q[0] != '0;
            mreq.addr = {ClsW'(0), head_q[0]};
            state_d = scbrp_pkg::StEvScan;
          end
        end
      end
      default: state_d = scbrp_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
    sel_q <= sel_d;
    scan_q <= scan_d;
    best_age_q <= best_age_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scbrp_pkg::StIdle;
      for (int c = 0; c < Cnt; c++) begin
        head_q[c] <= '0;
        fill_q[c] <= '0;
      end
      tcount_q <= '0;
      tbytes_q <= '0;
      age_q <= '0;
      found_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q <= head_d;
      fill_q <= fill_d;
      tcount_q <= tcount_d;
      tbytes_q <= tbytes_d;
      age_q <= age_d;
      found_q <= found_d;
      ovalid_q <= ovalid_d;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != scbrp_pkg::StIdle |-> in_stall_o)
    else $error("accept while busy");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tcount_q <= 11'd1024)
    else $error("retained count out of range");

endmodule

// File: hw/rtl/scbrp_slot_mem.sv
// scbrp_slot_mem: handle and age storage, one write or read per cycle
// depends on scbrp_pkg
`timescale 1ns / 1ps
module scbrp_slot_mem (
  input  logic                 clk_i,
  input  logic                 re_i,
  input  scbrp_pkg::mem_req_t  req_i,
  output logic [31:0]          handle_o,
  output logic [31:0]          age_o
);

  localparam int Depth = scbrp_pkg::ClassCount * scbrp_pkg::ClassDepth;

  logic [31:0] handle_mem [Depth];
  logic [31:0] age_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      handle_mem[req_i.addr] <= req_i.handle;
      age_mem[req_i.addr] <= req_i.age;
    end
    if (re_i) begin
      handle_o <= handle_mem[req_i.addr];
      age_o <= age_mem[req_i.addr];
    end
  end

endmodule
